// ===== rtl/core/qst_pkg.sv =====
// Shared types, codes and helpers of the quoted separated tokenizer.
`timescale 1ns / 1ps
package qst_pkg;

  // Scanner phase
  typedef enum logic [2:0] {
    PH_LEAD,
    PH_UNQ,
    PH_QUOTED,
    PH_AFTERQ,
    PH_SCAN
  } phase_t;

  // Result kinds
  localparam logic [1:0] KIND_TOKEN = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_OPEN_QUOTE = 3'd1;
  localparam logic [2:0] ERR_EMPTY      = 3'd2;
  localparam logic [2:0] ERR_AFTER_Q    = 3'd3;
  localparam logic [2:0] ERR_DOUBLE_SEP = 3'd4;
  localparam logic [2:0] ERR_TRAIL_SEP  = 3'd5;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_QUOTE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEP   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALLOW = 2'd2;

  localparam logic [15:0] QUOTE_RESET = 16'd39;
  localparam logic [15:0] SEP_RESET   = 16'd44;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        quoted;
    logic        sepf;
    logic [2:0]  err;
    logic        done;
  } result_t;

  // Up to two results caused by one code unit
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } bundle_t;

  function automatic logic is_space(input logic [15:0] c);
    is_space = (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
               c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
               c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
               c == 16'h3000;
  endfunction

  function automatic result_t make_token(input logic [15:0] start, input logic [15:0] length,
                                         input logic quoted, input logic sepf,
                                         input logic done);
    make_token = '{kind: KIND_TOKEN, start: start, length: length, quoted: quoted,
                   sepf: sepf, err: ERR_NONE, done: done};
  endfunction

  function automatic result_t make_error(input logic [2:0] code);
    make_error = '{kind: KIND_ERROR, start: 16'd0, length: 16'd0, quoted: 1'b0,
                   sepf: 1'b0, err: code, done: 1'b1};
  endfunction

  function automatic result_t make_done();
    make_done = '{kind: KIND_DONE, start: 16'd0, length: 16'd0, quoted: 1'b0,
                  sepf: 1'b0, err: ERR_NONE, done: 1'b1};
  endfunction

endpackage

// ===== rtl/core/qst_front.sv =====
// Front end: configuration registers and the per-unit scanner that builds result bundles.
`timescale 1ns / 1ps
module qst_front import qst_pkg::*; #(
  parameter int INDEX_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [15:0]            s_tdata,
  input  logic                   s_tlast,
  input  logic                   q_full,
  output logic                   q_push,
  output bundle_t                q_data
);

  localparam logic [INDEX_BITS-1:0] IDX_ONE = INDEX_BITS'(1);
  localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

  logic [15:0] quote_char;
  logic [15:0] separator_char;
  logic        allow_quoted;

  phase_t                  phase, phase_next;
  logic [INDEX_BITS-1:0]   position, position_next;
  logic [INDEX_BITS-1:0]   cur_start, cur_start_next;
  logic [INDEX_BITS-1:0]   cur_length, cur_length_next;
  logic                    cur_quoted, cur_quoted_next;
  logic [1:0]              sep_count, sep_count_next;
  logic [INDEX_BITS-1:0]   pend_start, pend_start_next;
  logic [INDEX_BITS-1:0]   pend_length, pend_length_next;
  logic                    pend_quoted, pend_quoted_next;
  logic                    error_hold, error_hold_next;

  logic        fire;
  logic        is_q, is_sep, is_sp;
  logic        do_start, do_finish, fin_sep, emit_pend, end_valid;
  logic [2:0]  err;
  result_t     pend_res, end_res;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign fire      = s_tvalid && s_tready;

  assign is_q   = (s_tdata == quote_char);
  assign is_sep = (s_tdata == separator_char);
  assign is_sp  = is_space(s_tdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_char     <= QUOTE_RESET;
      separator_char <= SEP_RESET;
      allow_quoted   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_QUOTE: quote_char     <= cfg_data;
        CFG_SEP:   separator_char <= cfg_data;
        CFG_ALLOW: allow_quoted   <= cfg_data[0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEAD;
      position    <= '0;
      cur_start   <= '0;
      cur_length  <= '0;
      cur_quoted  <= 1'b0;
      sep_count   <= 2'd0;
      pend_start  <= '0;
      pend_length <= '0;
      pend_quoted <= 1'b0;
      error_hold  <= 1'b0;
    end else if (fire) begin
      phase       <= phase_next;
      position    <= position_next;
      cur_start   <= cur_start_next;
      cur_length  <= cur_length_next;
      cur_quoted  <= cur_quoted_next;
      sep_count   <= sep_count_next;
      pend_start  <= pend_start_next;
      pend_length <= pend_length_next;
      pend_quoted <= pend_quoted_next;
      error_hold  <= error_hold_next;
    end
  end

  // Held token, emitted when the next token opens
  assign pend_res = make_token(16'(pend_start), 16'(pend_length), pend_quoted,
                               sep_count != 2'd0, 1'b0);

  always_comb begin
    phase_next       = phase;
    cur_start_next   = cur_start;
    cur_length_next  = cur_length;
    cur_quoted_next  = cur_quoted;
    sep_count_next   = sep_count;
    pend_start_next  = pend_start;
    pend_length_next = pend_length;
    pend_quoted_next = pend_quoted;
    error_hold_next  = error_hold;
    do_start  = 1'b0;
    do_finish = 1'b0;
    fin_sep   = 1'b0;
    emit_pend = 1'b0;
    end_valid = 1'b0;
    err       = ERR_NONE;
    end_res   = make_done();

    if (!error_hold) begin
      unique case (phase)
        PH_LEAD: begin
          if (!is_sp) do_start = 1'b1;
        end
        PH_UNQ: begin
          if (is_sep) begin
            do_finish = 1'b1;
            fin_sep   = 1'b1;
          end else if (is_sp) begin
            do_finish = 1'b1;
          end else if (cur_length != IDX_MAX) begin
            cur_length_next = cur_length + IDX_ONE;
          end
        end
        PH_QUOTED: begin
          if (is_q) phase_next = PH_AFTERQ;
          else if (cur_length != IDX_MAX) cur_length_next = cur_length + IDX_ONE;
        end
        PH_AFTERQ: begin
          if (is_sep) begin
            do_finish = 1'b1;
            fin_sep   = 1'b1;
          end else if (is_sp) begin
            do_finish = 1'b1;
          end else begin
            err = ERR_AFTER_Q;
          end
        end
        PH_SCAN: begin
          if (is_sep) begin
            sep_count_next = sep_count + 2'd1;
            if (sep_count != 2'd0) err = ERR_DOUBLE_SEP;
          end else if (!is_sp) begin
            if (pend_length == '0) begin
              err = ERR_EMPTY;
            end else begin
              emit_pend      = 1'b1;
              sep_count_next = 2'd0;
              do_start       = 1'b1;
            end
          end
        end
        default: ;
      endcase

      // Open a token at this unit
      if (do_start) begin
        if (allow_quoted && is_q) begin
          cur_start_next  = position + IDX_ONE;
          cur_length_next = '0;
          cur_quoted_next = 1'b1;
          phase_next      = PH_QUOTED;
        end else if (is_sep) begin
          cur_start_next  = position;
          cur_length_next = '0;
          cur_quoted_next = 1'b0;
          do_finish       = 1'b1;
          fin_sep         = 1'b1;
        end else begin
          cur_start_next  = position;
          cur_length_next = IDX_ONE;
          cur_quoted_next = 1'b0;
          phase_next      = PH_UNQ;
        end
      end

      // Move the finished token to the pending slot
      if (do_finish) begin
        pend_start_next  = cur_start_next;
        pend_length_next = cur_length_next;
        pend_quoted_next = cur_quoted_next;
        sep_count_next   = {1'b0, fin_sep};
        phase_next       = PH_SCAN;
      end

      if (err == ERR_NONE && s_tlast) begin
        unique case (phase_next)
          PH_LEAD: begin
            end_valid = 1'b1;
            end_res   = make_done();
          end
          PH_UNQ: begin
            end_valid = 1'b1;
            end_res   = make_token(16'(cur_start_next), 16'(cur_length_next),
                                   1'b0, 1'b0, 1'b1);
          end
          PH_QUOTED: err = ERR_OPEN_QUOTE;
          PH_AFTERQ: begin
            if (cur_length_next == '0) begin
              err = ERR_EMPTY;
            end else begin
              end_valid = 1'b1;
              end_res   = make_token(16'(cur_start_next), 16'(cur_length_next),
                                     1'b1, 1'b0, 1'b1);
            end
          end
          PH_SCAN: begin
            if (sep_count_next != 2'd0) begin
              err = ERR_TRAIL_SEP;
            end else if (pend_length_next == '0) begin
              err = ERR_EMPTY;
            end else begin
              end_valid = 1'b1;
              end_res   = make_token(16'(pend_start_next), 16'(pend_length_next),
                                     pend_quoted_next, 1'b0, 1'b1);
            end
          end
          default: ;
        endcase
      end

      if (err != ERR_NONE) begin
        end_valid       = 1'b1;
        end_res         = make_error(err);
        error_hold_next = 1'b1;
      end
    end

    // A last unit always restarts the scan for the next string
    if (s_tlast) begin
      position_next    = '0;
      phase_next       = PH_LEAD;
      cur_start_next   = '0;
      cur_length_next  = '0;
      cur_quoted_next  = 1'b0;
      sep_count_next   = 2'd0;
      pend_start_next  = '0;
      pend_length_next = '0;
      pend_quoted_next = 1'b0;
      error_hold_next  = 1'b0;
    end else begin
      position_next = position + IDX_ONE;
    end
  end

  assign q_push        = fire && (emit_pend || end_valid);
  assign q_data.first  = emit_pend ? pend_res : end_res;
  assign q_data.second = end_res;
  assign q_data.two    = emit_pend && end_valid;

`ifndef SYNTH
  a_hold_silent: assert property (@(posedge clk) disable iff (rst)
    (fire && error_hold) |-> !q_push)
    else $error("result produced while an error is held");
`endif

endmodule

// ===== rtl/core/qst_fifo.sv =====
// Short queue of result bundles between the scanner and the output stage.
`timescale 1ns / 1ps
module qst_fifo import qst_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output bundle_t head_data
);

  bundle_t               mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full       = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + QUEUE_AW'(1);
      case ({push, pop})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue read while empty");
`endif

endmodule

// ===== rtl/core/qst_back.sv =====
// Back end: unpacks each bundle into one or two results on a registered output.
`timescale 1ns / 1ps
module qst_back import qst_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    head_valid,
  input  bundle_t head_data,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res,
  output logic    out_last
);

  logic sel;
  logic load;
  logic more;

  assign load = head_valid && (!out_valid || out_ready);
  // A second result of the bundle still follows
  assign more = head_data.two && !sel;
  assign pop  = load && !more;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      sel       <= more;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res  <= sel ? head_data.second : head_data.first;
      out_last <= !more;
    end
  end

`ifndef SYNTH
  a_first_is_token: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (out_res.kind == KIND_TOKEN && !out_res.done))
    else $error("non-final result of a unit is not a plain token");
`endif

endmodule

// ===== rtl/core/quoted_separated_tokenizer_top.sv =====
// Top level of the quoted separated tokenizer.
//
// Usage: code units of a string arrive on the s_ channel, one per transaction,
// with s_tlast on the final unit. Each result leaves on the m_ channel: m_tuser
// gives the kind (token, error, string finished), m_tdata the token fields, and
// m_tlast marks the last result caused by one input unit.
// Configuration: cfg_index 0 quote char, 1 separator char, 2 allow-quoted
// (bit 0); cfg_ready is always high; write only while the block is idle.
// The results of an accepted unit are written to the bundle queue, then loaded
// into the output register that drives m_tvalid.
// Throughput: one code unit per cycle while the queue is not full; a unit that
// causes two results sends them as two output transfers, absorbed by a
// four-bundle queue between scanner and output register.
// Reset: config returns to quote 39, separator 44, quoting off; a new string
// starts at index zero.
// Stall: when m_tready is low the queue fills and s_tready drops; nothing is
// lost and results stay in order.
`timescale 1ns / 1ps
module quoted_separated_tokenizer_top import qst_pkg::*; #(
  parameter int INDEX_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [15:0]            s_tdata,   // code_unit
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // token_start[15:0], token_length[31:16], was_quoted[32], separator_followed[33],
  // error_code[36:34], string_done[37], zero pad[39:38]
  output logic [39:0]            m_tdata,
  output logic [1:0]             m_tuser,   // kind
  output logic                   m_tlast
);

  bundle_t push_data;
  bundle_t head_data;
  result_t out_res;
  logic    push, full, pop, head_valid;

  qst_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_full    (full),
    .q_push    (push),
    .q_data    (push_data)
  );

  qst_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  qst_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (out_res),
    .out_last   (m_tlast)
  );

  assign m_tdata = {2'b00, out_res.done, out_res.err, out_res.sepf, out_res.quoted,
                    out_res.length, out_res.start};
  assign m_tuser = out_res.kind;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the quoted separated tokenizer top level.
`timescale 1ns / 1ps
module tb;
  import qst_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;  // no register behind it
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [15:0] code;
    logic        last;
  } unit_t;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        quoted;
    logic        sepf;
    logic [2:0]  err;
    logic        done;
    logic        last;
  } scan_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]            cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [15:0]            s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [39:0]            m_tdata;
  logic [1:0]             m_tuser;
  logic                   m_tlast;

  quoted_separated_tokenizer_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Scanner copy: configuration and per-string state
  logic [15:0] quote_cfg = QUOTE_RESET;
  logic [15:0] sep_cfg = SEP_RESET;
  logic        allow_cfg = 1'b0;
  logic [15:0] unit_pos = '0;
  phase_t      ph = PH_LEAD;
  logic [15:0] cur_start = '0;
  logic [15:0] cur_len = '0;
  logic        cur_quoted = 1'b0;
  int unsigned sep_cnt = 0;
  logic        pend_valid = 1'b0;
  logic [15:0] pend_start = '0;
  logic [15:0] pend_len = '0;
  logic        pend_quoted = 1'b0;
  logic        err_hold = 1'b0;

  scan_result_t expected_results[$];
  int           step_count;

  unit_t       unit_fifo[$];
  logic [15:0] string_units[$];
  unit_t       next_unit;
  int          units_queued = 0;
  int          units_taken = 0;
  int          src_gap = 0;
  int          sink_gap = 0;
  bit          idle_on = 1'b1;
  logic        squeeze_req = 1'b0;
  logic        squeeze_used = 1'b0;
  int          squeeze_left = 0;
  int          cycle_count = 0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          tokens_seen = 0;
  int          errors_seen = 0;
  int          empties_seen = 0;
  int          settings_count = 0;

  function automatic logic is_blank(input logic [15:0] c);
    return (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
           c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
           c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
           c == 16'h3000;
  endfunction

  function automatic void new_string();
    unit_pos = '0;
    ph = PH_LEAD;
    cur_start = '0;
    cur_len = '0;
    cur_quoted = 1'b0;
    sep_cnt = 0;
    pend_valid = 1'b0;
    pend_start = '0;
    pend_len = '0;
    pend_quoted = 1'b0;
    err_hold = 1'b0;
  endfunction

  function automatic void queue_result(input logic [1:0] kind, input logic [15:0] start,
                                       input logic [15:0] length, input logic quoted,
                                       input logic sepf, input logic [2:0] err,
                                       input logic done);
    scan_result_t r;
    r = '{kind: kind, start: start, length: length, quoted: quoted, sepf: sepf,
          err: err, done: done, last: 1'b0};
    expected_results.push_back(r);
    step_count++;
  endfunction

  function automatic void close_token(input int unsigned sep);
    pend_valid = 1'b1;
    pend_start = cur_start;
    pend_len = cur_len;
    pend_quoted = cur_quoted;
    sep_cnt = sep;
    ph = PH_SCAN;
  endfunction

  function automatic void open_token(input logic [15:0] c, input logic [15:0] pos);
    if (allow_cfg && c == quote_cfg) begin
      cur_start = pos + 16'd1;
      cur_len = '0;
      cur_quoted = 1'b1;
      ph = PH_QUOTED;
    end else if (c == sep_cfg) begin
      cur_start = pos;
      cur_len = '0;
      cur_quoted = 1'b0;
      close_token(1);
    end else begin
      cur_start = pos;
      cur_len = 16'd1;
      cur_quoted = 1'b0;
      ph = PH_UNQ;
    end
  endfunction

  function automatic void grow_token();
    if (cur_len != 16'hFFFF) cur_len++;
  endfunction

  // Advance the scanner copy by one code unit and queue the results it causes
  function automatic void scan_unit(input logic [15:0] c, input logic last);
    logic [15:0] pos;
    logic [2:0]  err;
    pos = unit_pos;
    err = ERR_NONE;
    step_count = 0;
    if (err_hold) begin
      if (last) new_string();
      else unit_pos = pos + 16'd1;
      return;
    end
    case (ph)
      PH_LEAD: begin
        if (!is_blank(c)) open_token(c, pos);
      end
      PH_UNQ: begin
        if (c == sep_cfg) close_token(1);
        else if (is_blank(c)) close_token(0);
        else grow_token();
      end
      PH_QUOTED: begin
        if (c == quote_cfg) ph = PH_AFTERQ;
        else grow_token();
      end
      PH_AFTERQ: begin
        if (c == sep_cfg) close_token(1);
        else if (is_blank(c)) close_token(0);
        else err = ERR_AFTER_Q;
      end
      default: begin
        if (c == sep_cfg) begin
          sep_cnt++;
          if (sep_cnt > 1) err = ERR_DOUBLE_SEP;
        end else if (!is_blank(c)) begin
          // an empty token only shows once no separator error can follow it
          if (pend_valid && pend_len == 0) begin
            err = ERR_EMPTY;
          end else begin
            if (pend_valid)
              queue_result(KIND_TOKEN, pend_start, pend_len, pend_quoted, sep_cnt != 0,
                           ERR_NONE, 1'b0);
            pend_valid = 1'b0;
            sep_cnt = 0;
            open_token(c, pos);
          end
        end
      end
    endcase

    if (err == ERR_NONE && last) begin
      case (ph)
        PH_LEAD: queue_result(KIND_DONE, '0, '0, 1'b0, 1'b0, ERR_NONE, 1'b1);
        PH_UNQ: queue_result(KIND_TOKEN, cur_start, cur_len, 1'b0, 1'b0, ERR_NONE, 1'b1);
        PH_QUOTED: err = ERR_OPEN_QUOTE;
        PH_AFTERQ: begin
          if (cur_len == 0) err = ERR_EMPTY;
          else queue_result(KIND_TOKEN, cur_start, cur_len, 1'b1, 1'b0, ERR_NONE, 1'b1);
        end
        default: begin
          if (sep_cnt != 0) err = ERR_TRAIL_SEP;
          else if (pend_len == 0) err = ERR_EMPTY;
          else queue_result(KIND_TOKEN, pend_start, pend_len, pend_quoted, 1'b0, ERR_NONE,
                            1'b1);
        end
      endcase
    end

    if (err != ERR_NONE) begin
      pend_valid = 1'b0;
      queue_result(KIND_ERROR, '0, '0, 1'b0, 1'b0, err, 1'b1);
      err_hold = 1'b1;
    end

    if (last) new_string();
    else unit_pos = pos + 16'd1;

    if (step_count > 0) expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, want %0h", results_seen, name,
                                got, want));
  endtask

  task automatic check_result();
    scan_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with none expected: kind %0d tdata %h", m_tuser,
                                m_tdata));
      return;
    end
    want = expected_results.pop_front();
    results_seen++;
    case (want.kind)
      KIND_TOKEN: tokens_seen++;
      KIND_ERROR: errors_seen++;
      default: empties_seen++;
    endcase
    check_field("kind", 16'(m_tuser), 16'(want.kind));
    check_field("token_start", m_tdata[15:0], want.start);
    check_field("token_length", m_tdata[31:16], want.length);
    check_field("was_quoted", 16'(m_tdata[32]), 16'(want.quoted));
    check_field("separator_followed", 16'(m_tdata[33]), 16'(want.sepf));
    check_field("error_code", 16'(m_tdata[36:34]), 16'(want.err));
    check_field("string_done", 16'(m_tdata[37]), 16'(want.done));
    check_field("pad", 16'(m_tdata[39:38]), 16'd0);
    check_field("last_in_run", 16'(m_tlast), 16'(want.last));
  endtask

  // Input side: one code unit per transaction, random bursts of idle cycles
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        scan_unit(s_tdata, s_tlast);
        units_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (unit_fifo.size() > 0) begin
          next_unit = unit_fifo.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= next_unit.code;
          s_tlast <= next_unit.last;
          if (idle_on && $urandom_range(0, 11) == 0) src_gap = $urandom_range(1, 13);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each transaction, stall in random bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (sink_gap > 0) sink_gap--;
      else if (idle_on && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 13);
      m_tready <= (sink_gap == 0) && (squeeze_left == 0);
    end
  end

  // Long hold-off of the output so the internal queue fills and the input stalls
  always @(posedge clk) begin
    if (squeeze_req && !squeeze_used) begin
      squeeze_used <= 1'b1;
      squeeze_left <= 400;
    end else if (squeeze_left > 0) begin
      squeeze_left <= squeeze_left - 1;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d results still expected", cycle_count,
             expected_results.size());
    $display("quoted_separated_tokenizer_top verification failed");
    $finish;
  end

  function automatic logic [15:0] pick_blank();
    logic [15:0] c;
    int k;
    do begin
      k = $urandom_range(0, 24);
      if (k < 5) c = 16'h0009 + 16'(k);
      else if (k >= 9 && k <= 19) c = 16'h2000 + 16'(k - 9);
      else begin
        case (k)
          5: c = 16'h0020;
          6: c = 16'h0085;
          7: c = 16'h00A0;
          8: c = 16'h1680;
          20: c = 16'h2028;
          21: c = 16'h2029;
          22: c = 16'h202F;
          23: c = 16'h205F;
          default: c = 16'h3000;
        endcase
      end
    end while (c == quote_cfg || c == sep_cfg);
    return c;
  endfunction

  function automatic logic [15:0] pick_plain();
    logic [15:0] c;
    do begin
      if ($urandom_range(0, 2) == 0) c = 16'($urandom_range(0, 65535));
      else c = 16'h0061 + 16'($urandom_range(0, 25));
    end while (is_blank(c) || c == quote_cfg || c == sep_cfg);
    return c;
  endfunction

  function automatic logic [15:0] pick_any();
    logic [15:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c = pick_plain();
      4, 5: c = pick_blank();
      6: c = sep_cfg;
      7: c = quote_cfg;
      default: c = 16'($urandom_range(0, 65535));
    endcase
    return c;
  endfunction

  // Move the collected string to the input queue, last unit marked
  function automatic void flush_string();
    unit_t u;
    int i;
    for (i = 0; i < string_units.size(); i++) begin
      u.code = string_units[i];
      u.last = (i == string_units.size() - 1);
      unit_fifo.push_back(u);
    end
    units_queued += string_units.size();
    string_units.delete();
  endfunction

  function automatic void add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) string_units.push_back({8'h00, s[i]});
    flush_string();
  endfunction

  // Tokens split by blanks or one separator, some quoted, random content
  function automatic void add_clean_string();
    int ntok;
    int t;
    ntok = $urandom_range(1, 4);
    repeat ($urandom_range(0, 2)) string_units.push_back(pick_blank());
    for (t = 0; t < ntok; t++) begin
      if (t > 0) begin
        if ($urandom_range(0, 1) == 1) begin
          repeat ($urandom_range(0, 2)) string_units.push_back(pick_blank());
          string_units.push_back(sep_cfg);
          repeat ($urandom_range(0, 2)) string_units.push_back(pick_blank());
        end else begin
          repeat ($urandom_range(1, 3)) string_units.push_back(pick_blank());
        end
      end
      if (allow_cfg && $urandom_range(0, 2) == 0) begin
        string_units.push_back(quote_cfg);
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 5))
            0: string_units.push_back(pick_blank());
            1: string_units.push_back(sep_cfg);
            default: string_units.push_back(pick_plain());
          endcase
        end
        string_units.push_back(quote_cfg);
      end else begin
        repeat ($urandom_range(1, 6)) string_units.push_back(pick_plain());
      end
    end
    repeat ($urandom_range(0, 2)) string_units.push_back(pick_blank());
    flush_string();
  endfunction

  function automatic void random_strings(input int count);
    int goal;
    goal = units_queued + count;
    while (units_queued < goal) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 10)) string_units.push_back(pick_any());
        flush_string();
      end else begin
        add_clean_string();
      end
    end
  endfunction

  task automatic wait_idle();
    while (!(units_taken == units_queued && expected_results.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write every register in turn, plus the unused index, holding valid across writes
  task automatic set_regs(input logic [15:0] quote, input logic [15:0] sep,
                          input logic allow);
    logic [CFG_INDEX_W-1:0] idx [4];
    logic [15:0]            val [4];
    logic [15:0]            noise;
    int i;
    noise = 16'($urandom_range(0, 65535));
    idx[0] = CFG_QUOTE;
    idx[1] = CFG_SEP;
    idx[2] = CFG_ALLOW;
    idx[3] = CFG_SPARE;
    val[0] = quote;
    val[1] = sep;
    val[2] = {noise[15:1], allow};
    val[3] = 16'($urandom_range(0, 65535));
    for (i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!(cfg_valid && cfg_ready));
      case (idx[i])
        CFG_QUOTE: quote_cfg = val[i];
        CFG_SEP: sep_cfg = val[i];
        CFG_ALLOW: allow_cfg = val[i][0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  initial begin
    logic [15:0] same;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset values: quoting off, so the quote is an ordinary character
    add_text(" ");
    add_text("ab,c");
    add_text("a,,b");
    add_text("x,");
    add_text(",y");
    string_units.push_back(16'hFFFF);
    string_units.push_back(16'h0000);
    string_units.push_back(16'h200A);
    string_units.push_back(16'h0008);
    string_units.push_back(16'h000E);
    string_units.push_back(16'h3000);
    string_units.push_back(16'h1FFF);
    string_units.push_back(16'h200B);
    flush_string();
    wait_idle();

    set_regs(QUOTE_RESET, SEP_RESET, 1'b1);
    add_text("'x,'");
    add_text("'a");
    add_text("''x");
    wait_idle();

    set_regs(16'h0000, 16'hFFFF, 1'b1);
    random_strings(80);
    wait_idle();

    set_regs(16'hFFFF, 16'h0000, 1'b0);
    random_strings(80);
    wait_idle();

    set_regs(QUOTE_RESET, SEP_RESET, 1'b1);
    squeeze_req <= 1'b1;
    random_strings(80);
    wait_idle();

    // quote and separator that are also blanks
    set_regs(16'h0020, 16'h0009, 1'b1);
    random_strings(80);
    wait_idle();

    same = 16'($urandom_range(0, 65535));
    set_regs(same, same, 1'b1);
    random_strings(80);
    wait_idle();

    set_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
             1'($urandom_range(0, 1)));
    random_strings(80);
    wait_idle();

    // full rate on both sides
    idle_on = 1'b0;
    set_regs(16'h0022, 16'h002C, 1'b1);
    random_strings(80);
    wait_idle();

    $display("Sent %0d code units under %0d register settings, with a long output hold-off",
             units_queued, settings_count);
    $display("Checked %0d results: %0d tokens, %0d errors, %0d empty strings", results_seen,
             tokens_seen, errors_seen, empties_seen);
    if (mismatches == 0) begin
      $display("quoted_separated_tokenizer_top verification clean");
    end else begin
      $display("quoted_separated_tokenizer_top verification failed");
    end
    $finish;
  end

endmodule
